[sv/range_assign_segment_tree_core_assert.svh]
// Assertion macros used by the segment tree sequencer.
// Needs nothing else; included by modules that check their own sequencing.
`ifndef RANGE_ASSIGN_SEGMENT_TREE_CORE_ASSERT_SVH
`define RANGE_ASSIGN_SEGMENT_TREE_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define RAST_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define RAST_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

[sv/rast_pkg.sv]
// Shared types and constants for the range-assign segment tree.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rast_pkg;

  localparam int LEAVES      = 1024;
  localparam int POS_W       = 11;
  localparam int NODES       = 4 * LEAVES;
  localparam int NODE_AW     = $clog2(NODES);
  localparam int STACK_DEPTH = 12;
  localparam int SP_W        = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_CLR  = 2'd1,
    PEND_SET  = 2'd2
  } pend_t;

  typedef enum logic [1:0] {
    PH_NEW,
    PH_LEFT,
    PH_RIGHT
  } phase_t;

  typedef struct packed {
    pend_t            pend;
    logic [POS_W-1:0] cnt;
  } node_t;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] addr;
    node_t              data;
  } node_wr_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_VISIT,
    S_PEND,
    S_PUSH_L,
    S_PUSH_R,
    S_DESC,
    S_SUM_L,
    S_SUM_R,
    S_SUM_WR,
    S_RET
  } state_t;

endpackage

[sv/rast_node_mem.sv]
// Node store: per-node set count and pending mark, heap indexed.
// One write and one registered read per cycle; uses rast_pkg.
`timescale 1ns / 1ps

module rast_node_mem import rast_pkg::*; (
  input  logic               clk,
  input  node_wr_t           wr,
  input  logic [NODE_AW-1:0] raddr,
  output node_t              rdata
);

  node_t mem [NODES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rast_ctrl.sv]
// Sequencer: walks the tree with an explicit frame stack, pushes pending
// marks down, rebuilds counts, clears the store. Uses rast_pkg, rast_node_mem.
`timescale 1ns / 1ps
`include "range_assign_segment_tree_core_assert.svh"

module rast_ctrl import rast_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear_req,
  input  logic [POS_W-1:0] size,
  input  logic             start,
  input  logic             empty,
  input  logic [POS_W-1:0] a_in,
  input  logic [POS_W-1:0] b_in,
  input  logic             set_in,
  output logic             busy,
  output logic             res_valid,
  output logic [POS_W-1:0] res_total,
  output logic [POS_W-1:0] res_change
);

  state_t state, state_next;

  logic [NODE_AW-1:0] stk_idx [STACK_DEPTH];
  logic [POS_W-1:0]   stk_lo  [STACK_DEPTH];
  logic [POS_W-1:0]   stk_hi  [STACK_DEPTH];
  phase_t             stk_ph  [STACK_DEPTH];
  logic [SP_W-1:0]    sp;

  logic [NODE_AW-1:0] clr_cnt;
  logic [POS_W-1:0]   a, b;
  pend_t              mark;
  pend_t              pmark;
  logic [POS_W-1:0]   lcnt;
  logic [POS_W-1:0]   root_total;
  logic [POS_W-1:0]   prev_total;

  node_wr_t           wr;
  logic [NODE_AW-1:0] raddr;
  node_t              rdata;

  logic [NODE_AW-1:0] cur_idx, left_idx, right_idx;
  logic [POS_W-1:0]   cur_lo, cur_hi, mid;
  logic [POS_W:0]     mid_sum;
  phase_t             cur_ph;

  // sequencer controls
  logic               do_init, do_push, do_pop, do_res, res_empty;
  logic               load_pmark, load_lcnt;
  phase_t             ph_val;
  logic [POS_W-1:0]   ch_lo, ch_hi;
  logic [NODE_AW-1:0] ch_idx;

  rast_node_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cur_idx   = stk_idx[sp];
  assign cur_lo    = stk_lo[sp];
  assign cur_hi    = stk_hi[sp];
  assign cur_ph    = stk_ph[sp];
  assign mid_sum   = {1'b0, cur_lo} + {1'b0, cur_hi};
  assign mid       = mid_sum[POS_W:1];
  assign left_idx  = {cur_idx[NODE_AW-2:0], 1'b0};
  assign right_idx = {cur_idx[NODE_AW-2:0], 1'b1};
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr         = '0;
    raddr      = cur_idx;
    do_init    = 1'b0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_res     = 1'b0;
    res_empty  = 1'b0;
    load_pmark = 1'b0;
    load_lcnt  = 1'b0;
    ph_val     = cur_ph;
    ch_idx     = left_idx;
    ch_lo      = cur_lo;
    ch_hi      = mid;
    case (state)
      S_CLEAR: begin
        wr.we   = 1'b1;
        wr.addr = clr_cnt;
        if (clr_cnt == NODE_AW'(NODES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (empty) begin
            do_res    = 1'b1;
            res_empty = 1'b1;
          end else begin
            do_init    = 1'b1;
            state_next = S_VISIT;
          end
        end
      end
      S_VISIT: begin
        if (a <= cur_lo && cur_hi <= b) begin
          wr.we       = 1'b1;
          wr.addr     = cur_idx;
          wr.data.pend = mark;
          wr.data.cnt = (mark == PEND_SET) ? (cur_hi - cur_lo + POS_W'(1)) : '0;
          state_next  = S_RET;
        end else begin
          state_next = S_PEND;
        end
      end
      S_PEND: begin
        load_pmark = 1'b1;
        state_next = (rdata.pend != PEND_NONE) ? S_PUSH_L : S_DESC;
      end
      S_PUSH_L: begin
        wr.we        = 1'b1;
        wr.addr      = left_idx;
        wr.data.pend = pmark;
        wr.data.cnt  = (pmark == PEND_SET) ? (mid - cur_lo + POS_W'(1)) : '0;
        state_next   = S_PUSH_R;
      end
      S_PUSH_R: begin
        wr.we        = 1'b1;
        wr.addr      = right_idx;
        wr.data.pend = pmark;
        wr.data.cnt  = (pmark == PEND_SET) ? (cur_hi - mid) : '0;
        state_next   = S_DESC;
      end
      S_DESC: begin
        if (cur_ph == PH_NEW && a <= mid) begin
          do_push    = 1'b1;
          ph_val     = PH_LEFT;
          state_next = S_VISIT;
        end else if (cur_ph != PH_RIGHT && mid < b) begin
          do_push    = 1'b1;
          ph_val     = PH_RIGHT;
          ch_idx     = right_idx;
          ch_lo      = mid + POS_W'(1);
          ch_hi      = cur_hi;
          state_next = S_VISIT;
        end else begin
          state_next = S_SUM_L;
        end
      end
      S_SUM_L: begin
        raddr      = left_idx;
        state_next = S_SUM_R;
      end
      S_SUM_R: begin
        raddr      = right_idx;
        load_lcnt  = 1'b1;
        state_next = S_SUM_WR;
      end
      S_SUM_WR: begin
        // any pending mark here was already pushed to the children
        wr.we        = 1'b1;
        wr.addr      = cur_idx;
        wr.data.pend = PEND_NONE;
        wr.data.cnt  = lcnt + rdata.cnt;
        state_next   = S_RET;
      end
      S_RET: begin
        if (sp == '0) begin
          do_res     = 1'b1;
          state_next = S_IDLE;
        end else begin
          do_pop     = 1'b1;
          state_next = S_DESC;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    if (clear_req) begin
      state_next = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp         <= '0;
      clr_cnt    <= '0;
      root_total <= '0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= do_res;
      if (clear_req) begin
        clr_cnt    <= '0;
        root_total <= '0;
      end else begin
        if (state == S_CLEAR) begin
          clr_cnt <= clr_cnt + NODE_AW'(1);
        end
        if (wr.we && state != S_CLEAR && wr.addr == NODE_AW'(1)) begin
          root_total <= wr.data.cnt;
        end
      end
      if (do_init) begin
        sp <= '0;
      end else if (do_push) begin
        sp <= sp + SP_W'(1);
      end else if (do_pop) begin
        sp <= sp - SP_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (do_init) begin
      stk_idx[0] <= NODE_AW'(1);
      stk_lo[0]  <= POS_W'(1);
      stk_hi[0]  <= size;
      stk_ph[0]  <= PH_NEW;
      a          <= a_in;
      b          <= b_in;
      mark       <= set_in ? PEND_SET : PEND_CLR;
      prev_total <= root_total;
    end
    if (do_push) begin
      stk_ph[sp]            <= ph_val;
      stk_idx[sp + SP_W'(1)] <= ch_idx;
      stk_lo[sp + SP_W'(1)]  <= ch_lo;
      stk_hi[sp + SP_W'(1)]  <= ch_hi;
      stk_ph[sp + SP_W'(1)]  <= PH_NEW;
    end
    if (load_pmark) begin
      pmark <= rdata.pend;
    end
    if (load_lcnt) begin
      lcnt <= rdata.cnt;
    end
    if (do_res) begin
      res_total <= root_total;
      if (res_empty) begin
        res_change <= '0;
      end else begin
        res_change <= (root_total >= prev_total) ? (root_total - prev_total)
                                                 : (prev_total - root_total);
      end
    end
  end

  `RAST_ASSERT_IMP(a_sp_bound, clk, rst, state != S_IDLE, sp <= SP_W'(STACK_DEPTH - 1), "sp")
  `RAST_ASSERT_IMP(a_total_bound, clk, rst, state == S_IDLE, root_total <= size, "total")
  `RAST_ASSERT_IMP(a_leaf_covered, clk, rst, state == S_PEND, cur_lo != cur_hi, "leaf")
  `RAST_ASSERT_NXT(a_root_result, clk, rst, state == S_RET && sp == '0 && !clear_req, res_valid, "res")

endmodule

[sv/range_assign_segment_tree_core.sv]
// Top level: size register, input clipping, tree sequencer.
// Uses rast_pkg and rast_ctrl.
`timescale 1ns / 1ps

// Range assign over a set-count segment tree of up to 1024 positions.
// Input beat: range_low, range_high, assign_value taken when start is high
// and busy is low. Each position in [range_low, range_high] becomes
// assign_value; range_low 0 acts as 1, range_high is clipped to the size.
// Result beat: total_set and change_amount, valid for one cycle with done.
// There is no output backpressure; every accepted beat gives one result
// unless size_we clears the tree first. Sequencing: an empty range raises
// done in the cycle after the accepting edge and busy stays low. Otherwise
// the walk takes each fully covered node through VISIT and RET, and each
// partly covered node through VISIT, PEND, the PUSH_L and PUSH_R writes when
// a mark is pending, DESC, SUM_L, SUM_R, SUM_WR and RET (one node-store port,
// read data registered); busy stays high until done. One beat is in flight at a time.
// Config: size_we/size_wdata set the active size (0 -> 1, above 1024 ->
// 1024) and clear the tree. Reset sets size 1024 and clears the tree.
// Clearing sweeps 4096 node entries, one per cycle, with busy high.

module range_assign_segment_tree_core import rast_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             size_we,
  input  logic [POS_W-1:0] size_wdata,
  input  logic             start,
  output logic             busy,
  input  logic [POS_W-1:0] range_low,
  input  logic [POS_W-1:0] range_high,
  input  logic             assign_value,
  output logic             done,
  output logic [POS_W-1:0] total_set,
  output logic [POS_W-1:0] change_amount
);

  logic [POS_W-1:0] size;
  logic [POS_W-1:0] size_clamped;
  logic [POS_W-1:0] lo, hi;
  logic             empty;

  always_comb begin
    size_clamped = size_wdata;
    if (size_wdata == '0) begin
      size_clamped = POS_W'(1);
    end else if (size_wdata > POS_W'(LEAVES)) begin
      size_clamped = POS_W'(LEAVES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= POS_W'(LEAVES);
    end else if (size_we) begin
      size <= size_clamped;
    end
  end

  assign lo    = (range_low == '0) ? POS_W'(1) : range_low;
  assign hi    = (range_high > size) ? size : range_high;
  assign empty = (lo > hi);

  rast_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .clear_req  (size_we),
    .size       (size),
    .start      (start),
    .empty      (empty),
    .a_in       (lo),
    .b_in       (hi),
    .set_in     (assign_value),
    .busy       (busy),
    .res_valid  (done),
    .res_total  (total_set),
    .res_change (change_amount)
  );

endmodule
